// ===== hw/rtl/srt_pkg.sv =====
// ----------------------------------------------------------------------------
// srt_pkg - shared types and constants for the subnet router table
// Table geometry, request and status codes, stored row layout, bus widths.
// ----------------------------------------------------------------------------
package srt_pkg;

	localparam int TableEntries = 64;
	localparam int MaxVlanId    = 4095;

	// slot index and scan counter widths (counter must also hold TableEntries)
	localparam int SlotW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
	localparam int CntW  = $clog2(TableEntries + 1);

	localparam int VlanInW = 16;
	localparam int VlanW   = 12;
	localparam int IpW     = 32;
	localparam int ReqW    = 3;
	localparam int StatW   = 2;

	localparam int STdataW = 128;
	localparam int STuserW = ReqW;
	localparam int MTdataW = 80;

	typedef enum logic [ReqW-1:0] {
		REQ_ADD    = 3'd0,
		REQ_MODIFY = 3'd1,
		REQ_DELETE = 3'd2,
		REQ_EXACT  = 3'd3,
		REQ_SUBNET = 3'd4
	} req_code_t;

	typedef enum logic [StatW-1:0] {
		STAT_OK       = 2'd0,
		STAT_BADVLAN  = 2'd1,
		STAT_NOTFOUND = 2'd2,
		STAT_FULL     = 2'd3
	} status_t;

	// one stored table row
	typedef struct packed {
		logic [VlanW-1:0] key_vlan;
		logic [IpW-1:0]   key_ip;
		logic [VlanW-1:0] out_vlan;
		logic [IpW-1:0]   mask;
	} entry_row_t;

	// captured request
	typedef struct packed {
		logic [ReqW-1:0]  req_type;
		logic [VlanW-1:0] key_vlan;
		logic [IpW-1:0]   key_ip;
		logic [VlanW-1:0] out_vlan;
		logic [IpW-1:0]   mask;
		logic [IpW-1:0]   dest;
	} req_fields_t;

endpackage

// ===== hw/rtl/subnet_router_table.sv =====
// ----------------------------------------------------------------------------
// subnet_router_table - VLAN/IPv4 keyed router table with subnet lookup
// Add, modify, delete, exact lookup and first-match subnet lookup over a
// table scanned one slot per cycle through a single shared comparator.
// ----------------------------------------------------------------------------
//
// Channel  | Dir | Signals                      | Carries
// ---------+-----+------------------------------+-------------------------------
// request  | in  | s_tvalid s_tready s_tdata    | one table request per beat
//          |     | s_tuser                      | request code
// result   | out | m_tvalid m_tready m_tdata    | one result beat per request
//
// Flow: a request rejected on VLAN range or carrying an unused code skips
//   the scan and goes straight to the finish state. Any other request scans
//   the table one slot per cycle, lowest first, through the read port of the row
//   memory and the one compare, stopping at the first match or the table end.
// Reset: arst_n clears the control state and every slot's valid bit at once;
//   no clearing pass, the table is usable as soon as reset is released.
// Stalls: s_tready is high only while idle. A finished result sits in the
//   output register, so a new request may be taken while m_tready is low; the
//   next result waits in the finish state until that register has drained.
//
module subnet_router_table (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// key_vlan[15:0], key_ip[47:16], new_out_vlan[63:48],
	// new_netmask[95:64], dest_addr[127:96]
	input  logic [srt_pkg::STdataW-1:0] s_tdata,
	// req_type[2:0]
	input  logic [srt_pkg::STuserW-1:0] s_tuser,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// status[1:0], hit[2], gw_ip[34:3], out_vlan[46:35],
	// netmask[78:47], zero[79]
	output logic [srt_pkg::MTdataW-1:0] m_tdata
);
	import srt_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DONE
	} state_t;

	// ------------------------------------------------------------------------
	// Request field extraction
	// ------------------------------------------------------------------------
	logic [VlanInW-1:0] in_key_vlan;
	logic [IpW-1:0]     in_key_ip;
	logic [VlanInW-1:0] in_out_vlan;
	logic [IpW-1:0]     in_mask;
	logic [IpW-1:0]     in_dest;
	logic [ReqW-1:0]    in_req;

	assign in_key_vlan = s_tdata[15:0];
	assign in_key_ip   = s_tdata[47:16];
	assign in_out_vlan = s_tdata[63:48];
	assign in_mask     = s_tdata[95:64];
	assign in_dest     = s_tdata[127:96];
	assign in_req      = s_tuser;

	// ------------------------------------------------------------------------
	// State
	// ------------------------------------------------------------------------
	state_t                 state_q;
	req_fields_t            req_q;
	logic                   skip_q;         // answer without a scan
	status_t                pre_status_q;   // status for the no-scan path
	logic [CntW-1:0]        idx_q;          // next slot to read
	logic                   found_q;
	logic [SlotW-1:0]       hit_slot_q;
	entry_row_t             hit_row_q;
	logic                   free_found_q;
	logic [SlotW-1:0]       free_slot_q;
	logic [TableEntries-1:0] entry_valid_q;

	// read stage of the scan
	logic             issue_s1;
	logic [SlotW-1:0] slot_s1;
	logic             valid_s1;
	entry_row_t       rd_row_s1;

	logic m_tvalid_q;
	logic [MTdataW-1:0] m_tdata_q;

	// ------------------------------------------------------------------------
	// Entry check on the incoming beat
	// ------------------------------------------------------------------------
	logic    in_accept;
	logic    in_skip;
	status_t in_status;

	assign in_accept = s_tvalid && s_tready;

	always_comb begin
		in_skip   = 1'b0;
		in_status = STAT_OK;
		unique case (in_req) inside
			REQ_ADD, REQ_MODIFY: begin
				if (in_key_vlan > VlanInW'(MaxVlanId) ||
				    in_out_vlan > VlanInW'(MaxVlanId)) begin
					in_skip   = 1'b1;
					in_status = STAT_BADVLAN;
				end
			end
			REQ_DELETE, REQ_EXACT: begin
				if (in_key_vlan > VlanInW'(MaxVlanId)) begin
					in_skip   = 1'b1;
					in_status = STAT_BADVLAN;
				end
			end
			REQ_SUBNET: begin
				in_skip = 1'b0;
			end
			default: begin
				// unused codes: no change, plain OK
				in_skip = 1'b1;
			end
		endcase
	end

	// ------------------------------------------------------------------------
	// Shared comparator: key match, or masked subnet match
	// ------------------------------------------------------------------------
	logic                 is_subnet;
	logic [VlanW+IpW-1:0] cmp_a;
	logic [VlanW+IpW-1:0] cmp_b;
	logic                 match;
	logic                 rd_en;
	logic                 scan_end;

	assign is_subnet = (req_q.req_type == REQ_SUBNET);

	always_comb begin
		if (is_subnet) begin
			cmp_a = {{VlanW{1'b0}}, rd_row_s1.key_ip & rd_row_s1.mask};
			cmp_b = {{VlanW{1'b0}}, req_q.dest & rd_row_s1.mask};
		end else begin
			cmp_a = {rd_row_s1.key_vlan, rd_row_s1.key_ip};
			cmp_b = {req_q.key_vlan, req_q.key_ip};
		end
	end

	// only compares made while scanning count; the slot read in the hit
	// cycle lands after the scan has stopped and is dropped
	assign match    = (state_q == S_SCAN) && issue_s1 && valid_s1 && (cmp_a == cmp_b);
	assign rd_en    = (state_q == S_SCAN) && (idx_q < CntW'(TableEntries));
	assign scan_end = (idx_q == CntW'(TableEntries));

	// ------------------------------------------------------------------------
	// Finish: table update and result beat
	// ------------------------------------------------------------------------
	logic             out_free;
	logic             finish;
	logic             wr_en;
	logic [SlotW-1:0] wr_slot;
	logic             valid_set;
	logic             valid_clr;
	entry_row_t       wr_row;
	status_t          res_status;
	logic             res_hit;

	assign out_free = !m_tvalid_q || m_tready;
	assign finish   = (state_q == S_DONE) && out_free;

	assign wr_row.key_vlan = req_q.key_vlan;
	assign wr_row.key_ip   = req_q.key_ip;
	assign wr_row.out_vlan = req_q.out_vlan;
	assign wr_row.mask     = req_q.mask;

	always_comb begin
		wr_en      = 1'b0;
		wr_slot    = hit_slot_q;
		valid_set  = 1'b0;
		valid_clr  = 1'b0;
		res_status = STAT_OK;
		res_hit    = 1'b0;
		if (skip_q) begin
			res_status = pre_status_q;
		end else begin
			unique case (req_q.req_type) inside
				REQ_ADD: begin
					if (found_q) begin
						wr_en = finish;
					end else if (free_found_q) begin
						wr_en     = finish;
						wr_slot   = free_slot_q;
						valid_set = finish;
					end else begin
						res_status = STAT_FULL;
					end
				end
				REQ_MODIFY: begin
					if (found_q)
						wr_en = finish;
					else
						res_status = STAT_NOTFOUND;
				end
				REQ_DELETE: begin
					if (found_q)
						valid_clr = finish;
					else
						res_status = STAT_NOTFOUND;
				end
				REQ_EXACT, REQ_SUBNET: begin
					if (found_q)
						res_hit = 1'b1;
					else
						res_status = STAT_NOTFOUND;
				end
				default: begin
					res_status = STAT_OK;
				end
			endcase
		end
	end

	logic [MTdataW-1:0] res_data;

	always_comb begin
		res_data = '0;
		res_data[1:0] = res_status;
		res_data[2]   = res_hit;
		if (res_hit) begin
			res_data[34:3]  = hit_row_q.key_ip;
			res_data[46:35] = hit_row_q.out_vlan;
			res_data[78:47] = hit_row_q.mask;
		end
	end

	// ------------------------------------------------------------------------
	// Row memory: one write port, one registered read port
	// ------------------------------------------------------------------------
	entry_row_t row_mem [TableEntries];

	always_ff @(posedge clk) begin
		if (wr_en)
			row_mem[wr_slot] <= wr_row;
		if (rd_en)
			rd_row_s1 <= row_mem[idx_q[SlotW-1:0]];
	end

	// ------------------------------------------------------------------------
	// Payload registers (no reset)
	// ------------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (in_accept) begin
			req_q.req_type <= in_req;
			req_q.key_vlan <= in_key_vlan[VlanW-1:0];
			req_q.key_ip   <= in_key_ip;
			req_q.out_vlan <= in_out_vlan[VlanW-1:0];
			req_q.mask     <= in_mask;
			req_q.dest     <= in_dest;
			pre_status_q   <= in_status;
		end
		if (rd_en) begin
			slot_s1  <= idx_q[SlotW-1:0];
			valid_s1 <= entry_valid_q[idx_q[SlotW-1:0]];
		end
		if (match) begin
			hit_slot_q <= slot_s1;
			hit_row_q  <= rd_row_s1;
		end
		if (issue_s1 && !valid_s1 && !free_found_q)
			free_slot_q <= slot_s1;
		if (finish)
			m_tdata_q <= res_data;
	end

	// ------------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			skip_q        <= 1'b0;
			idx_q         <= '0;
			found_q       <= 1'b0;
			free_found_q  <= 1'b0;
			issue_s1      <= 1'b0;
			entry_valid_q <= '0;
			m_tvalid_q    <= 1'b0;
		end else begin
			issue_s1 <= rd_en;

			if (m_tvalid_q && m_tready)
				m_tvalid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						skip_q       <= in_skip;
						idx_q        <= '0;
						found_q      <= 1'b0;
						free_found_q <= 1'b0;
						state_q      <= in_skip ? S_DONE : S_SCAN;
					end
				end
				S_SCAN: begin
					if (rd_en)
						idx_q <= idx_q + CntW'(1);
					if (issue_s1 && !valid_s1)
						free_found_q <= 1'b1;
					if (match) begin
						found_q <= 1'b1;
						state_q <= S_DONE;
					end else if (scan_end) begin
						// last compare, if any, was made this cycle
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						state_q    <= S_IDLE;
						if (valid_set)
							entry_valid_q[wr_slot] <= 1'b1;
						if (valid_clr)
							entry_valid_q[hit_slot_q] <= 1'b0;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// ------------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------------
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> !s_tready)
		else $error("request taken while another is in progress");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= CntW'(TableEntries))
		else $error("scan counter ran past the table");

	a_write_in_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en || valid_set || valid_clr) |-> finish)
		else $error("table changed outside the finish step");

	a_free_slot_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && free_found_q && !found_q) |-> !entry_valid_q[free_slot_q])
		else $error("recorded free slot is occupied");

	a_hit_ok: assert property (@(posedge clk) disable iff (!arst_n)
		finish && res_hit |-> (res_status == STAT_OK) && !skip_q)
		else $error("hit reported with a failing status");

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the subnet router table
// Drives add, modify, delete, exact and subnet lookup requests with random
// gaps and output stalls. A shadow copy of the table predicts each result
// beat, which is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_top;
	import srt_pkg::*;

	localparam int ClkHalf     = 6;
	localparam int ResetCycles = 3;
	localparam int RandomItems = 1750;
	localparam int PhaseItems  = 125;
	localparam int PoolSize    = 80;   // more keys than slots, so fill phases reach full
	localparam int MaxGap      = 5;
	localparam int TailCycles  = 80;   // outlasts the worst scan, which reads every slot
	localparam int CycleLimit  = 1000000;
	localparam int ReportLimit = 10;
	localparam logic [ReqW-1:0] ReqCodeTop = '1;

	// one request beat, fields as the block sees them
	typedef struct packed {
		logic [ReqW-1:0]    req_type;
		logic [VlanInW-1:0] key_vlan;
		logic [IpW-1:0]     key_ip;
		logic [VlanInW-1:0] new_out_vlan;
		logic [IpW-1:0]     new_netmask;
		logic [IpW-1:0]     dest_addr;
	} table_req_t;

	// one result beat
	typedef struct {
		status_t          status;
		logic             hit;
		logic [IpW-1:0]   gw_ip;
		logic [VlanW-1:0] out_vlan;
		logic [IpW-1:0]   netmask;
	} table_result_t;

	// request mix of a random phase
	typedef enum int {LOAD_FILL, LOAD_MIXED, LOAD_DRAIN} load_mode_t;

	// ------------------------------------------------------------------------
	// Shadow table: predicts each result from accepted requests and checks
	// result beats against the predictions in order.
	// ------------------------------------------------------------------------
	class router_table_shadow;
		bit               slot_valid    [TableEntries];
		logic [VlanW-1:0] slot_vlan     [TableEntries];
		logic [IpW-1:0]   slot_ip       [TableEntries];
		logic [VlanW-1:0] slot_out_vlan [TableEntries];
		logic [IpW-1:0]   slot_mask     [TableEntries];
		table_result_t    due_results[$];
		int unsigned      result_count;
		int unsigned      mismatch_count;
		int unsigned      hit_count;
		int unsigned      status_count [4];

		function new();
			for (int i = 0; i < TableEntries; i++) begin
				slot_valid[i]    = 1'b0;
				slot_vlan[i]     = '0;
				slot_ip[i]       = '0;
				slot_out_vlan[i] = '0;
				slot_mask[i]     = '0;
			end
			foreach (status_count[i]) status_count[i] = 0;
			result_count   = 0;
			mismatch_count = 0;
			hit_count      = 0;
		endfunction

		function int find_slot(logic [VlanW-1:0] vlan, logic [IpW-1:0] ip);
			for (int i = 0; i < TableEntries; i++)
				if (slot_valid[i] && slot_vlan[i] == vlan && slot_ip[i] == ip)
					return i;
			return -1;
		endfunction

		function void note_request(table_req_t q);
			table_result_t r;
			int            key_slot;
			int            hit_slot;
			int            free_slot;
			bit            bad_vlan;
			r.status    = STAT_OK;
			r.hit       = 1'b0;
			r.gw_ip     = '0;
			r.out_vlan  = '0;
			r.netmask   = '0;
			hit_slot    = -1;
			free_slot   = -1;
			// key checked first; the value VLAN only matters to add and modify
			bad_vlan = (q.key_vlan > MaxVlanId) ||
				((q.req_type == REQ_ADD || q.req_type == REQ_MODIFY) &&
				(q.new_out_vlan > MaxVlanId));
			case (q.req_type)
				REQ_SUBNET: begin
					// key VLAN plays no part; first masked match, lowest slot
					r.status = STAT_NOTFOUND;
					for (int i = 0; i < TableEntries && hit_slot < 0; i++)
						if (slot_valid[i] && ((slot_ip[i] ^ q.dest_addr) & slot_mask[i]) == '0)
							hit_slot = i;
					if (hit_slot >= 0) r.status = STAT_OK;
				end
				REQ_ADD, REQ_MODIFY, REQ_DELETE, REQ_EXACT: begin
					if (bad_vlan) begin
						r.status = STAT_BADVLAN;
					end else begin
						key_slot = find_slot(q.key_vlan[VlanW-1:0], q.key_ip);
						if (q.req_type == REQ_ADD) begin
							if (key_slot < 0) begin
								for (int i = 0; i < TableEntries && free_slot < 0; i++)
									if (!slot_valid[i]) free_slot = i;
								if (free_slot >= 0) begin
									key_slot            = free_slot;
									slot_valid[key_slot] = 1'b1;
									slot_vlan[key_slot]  = q.key_vlan[VlanW-1:0];
									slot_ip[key_slot]    = q.key_ip;
								end
							end
							if (key_slot < 0) begin
								r.status = STAT_FULL;
							end else begin
								slot_out_vlan[key_slot] = q.new_out_vlan[VlanW-1:0];
								slot_mask[key_slot]     = q.new_netmask;
							end
						end else if (key_slot < 0) begin
							r.status = STAT_NOTFOUND;
						end else if (q.req_type == REQ_MODIFY) begin
							slot_out_vlan[key_slot] = q.new_out_vlan[VlanW-1:0];
							slot_mask[key_slot]     = q.new_netmask;
						end else if (q.req_type == REQ_DELETE) begin
							slot_valid[key_slot] = 1'b0;
						end else begin
							hit_slot = key_slot;
						end
					end
				end
				default: ; // spare codes: no change, status ok
			endcase
			if (hit_slot >= 0) begin
				r.hit       = 1'b1;
				r.gw_ip     = slot_ip[hit_slot];
				r.out_vlan  = slot_out_vlan[hit_slot];
				r.netmask   = slot_mask[hit_slot];
				hit_count++;
			end
			status_count[r.status]++;
			due_results.push_back(r);
		endfunction

		function void check_result(logic [MTdataW-1:0] beat);
			table_result_t want;
			table_result_t got;
			logic          pad;
			got.status    = status_t'(beat[1:0]);
			got.hit       = beat[2];
			got.gw_ip     = beat[34:3];
			got.out_vlan  = beat[46:35];
			got.netmask   = beat[78:47];
			pad           = beat[79];
			if (due_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= ReportLimit)
					$display("[%0t] result beat %h with no request outstanding", $realtime, beat);
				return;
			end
			want = due_results.pop_front();
			result_count++;
			if (got.status !== want.status || got.hit !== want.hit ||
				got.gw_ip !== want.gw_ip || got.out_vlan !== want.out_vlan ||
				got.netmask !== want.netmask || pad !== 1'b0) begin
				mismatch_count++;
				if (mismatch_count <= ReportLimit)
					$display({"[%0t] result %0d: want st %0d hit %0b ip %h vlan %h mask %h,",
						" got st %0d hit %0b ip %h vlan %h mask %h pad %b"},
						$realtime, result_count, want.status, want.hit, want.gw_ip,
						want.out_vlan, want.netmask, got.status, got.hit, got.gw_ip,
						got.out_vlan, got.netmask, pad);
			end
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Clock, reset, block under test
	// ------------------------------------------------------------------------
	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [STdataW-1:0]  s_tdata;
	logic [STuserW-1:0]  s_tuser;
	logic                m_tvalid;
	logic                m_tready;
	logic [MTdataW-1:0]  m_tdata;

	router_table_shadow  shadow;
	bit                  no_gaps;      // both sides run flat out while set
	int unsigned         cycle_count;
	logic [VlanW-1:0]    pool_vlan [PoolSize];
	logic [IpW-1:0]      pool_ip   [PoolSize];
	int unsigned         fill_ptr;

	initial begin
		clk = 1'b0;
		forever #ClkHalf clk = ~clk;
	end

	subnet_router_table DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// watchdog: ends the run if it hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CycleLimit) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("end of test: mismatches");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------
	// mostly contiguous prefixes, now and then an arbitrary bit pattern
	function automatic logic [IpW-1:0] prefix_mask();
		int unsigned len;
		len = $urandom_range(0, IpW);
		if ($urandom_range(0, 4) == 0) return $urandom;
		if (len == 0) return '0;
		return ~32'h0 << (IpW - len);
	endfunction

	function automatic table_req_t build_req(logic [ReqW-1:0] op, logic [VlanInW-1:0] kv,
		logic [IpW-1:0] ip, logic [VlanInW-1:0] ov, logic [IpW-1:0] nm, logic [IpW-1:0] da);
		table_req_t q;
		q.req_type     = op;
		q.key_vlan     = kv;
		q.key_ip       = ip;
		q.new_out_vlan = ov;
		q.new_netmask  = nm;
		q.dest_addr    = da;
		return q;
	endfunction

	function automatic table_req_t pick_request(load_mode_t mode);
		table_req_t  q;
		req_code_t   op;
		int unsigned roll;
		int unsigned k;
		int unsigned slot;
		roll = $urandom_range(0, 99);
		// noise: any code, any field value
		if (roll < 6) begin
			q = build_req(ReqW'($urandom_range(0, ReqCodeTop)), VlanInW'($urandom), $urandom,
				VlanInW'($urandom), $urandom, $urandom);
			return q;
		end
		roll = $urandom_range(0, 99);
		case (mode)
			LOAD_FILL:
				op = roll < 80 ? REQ_ADD : roll < 88 ? REQ_EXACT :
					roll < 96 ? REQ_SUBNET : REQ_MODIFY;
			LOAD_DRAIN:
				op = roll < 50 ? REQ_DELETE : roll < 60 ? REQ_ADD :
					roll < 75 ? REQ_EXACT : REQ_SUBNET;
			default:
				op = roll < 25 ? REQ_ADD : roll < 40 ? REQ_MODIFY :
					roll < 55 ? REQ_DELETE : roll < 75 ? REQ_EXACT : REQ_SUBNET;
		endcase
		q = build_req(op, '0, '0, VlanInW'($urandom_range(0, MaxVlanId)), prefix_mask(),
			$urandom);
		// fill phases walk the pool in order, so adds take each pool key in turn
		if (mode == LOAD_FILL && op == REQ_ADD) begin
			k        = fill_ptr;
			fill_ptr = (fill_ptr + 1) % PoolSize;
			q.key_vlan = pool_vlan[k];
			q.key_ip   = pool_ip[k];
		end else if ($urandom_range(0, 9) == 0) begin
			q.key_vlan = VlanInW'($urandom_range(0, MaxVlanId));
			q.key_ip   = $urandom;
		end else begin
			k = $urandom_range(0, PoolSize - 1);
			q.key_vlan = pool_vlan[k];
			q.key_ip   = pool_ip[k];
		end
		if ($urandom_range(0, 29) == 0)
			q.key_vlan = VlanInW'($urandom_range(MaxVlanId + 1, 16'hFFFF));
		if ($urandom_range(0, 29) == 0)
			q.new_out_vlan = VlanInW'($urandom_range(MaxVlanId + 1, 16'hFFFF));
		// aim most subnet lookups inside the subnet of a drawn slot, if it is live
		if (op == REQ_SUBNET && $urandom_range(0, 99) < 65) begin
			slot = $urandom_range(0, TableEntries - 1);
			if (shadow.slot_valid[slot])
				q.dest_addr = (shadow.slot_ip[slot] & shadow.slot_mask[slot]) |
					($urandom & ~shadow.slot_mask[slot]);
		end
		return q;
	endfunction

	// ------------------------------------------------------------------------
	// Request side: optional gap, then hold the beat until s_tready is seen
	// at a rising edge. Back-to-back beats keep s_tvalid high throughout.
	// ------------------------------------------------------------------------
	task automatic send_req(table_req_t q);
		int unsigned gap;
		gap = no_gaps ? 0 : $urandom_range(0, MaxGap);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= q.req_type;
		s_tdata  <= {q.dest_addr, q.new_netmask, q.new_out_vlan, q.key_ip, q.key_vlan};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		shadow.note_request(q);
	endtask

	// ------------------------------------------------------------------------
	// Result side: stall for a drawn number of cycles, then take one beat
	// ------------------------------------------------------------------------
	initial begin : result_sink
		int unsigned stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = no_gaps ? 0 : $urandom_range(0, MaxGap);
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			shadow.check_result(m_tdata);
		end
	end

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin : main_seq
		load_mode_t mode;
		shadow      = new();
		no_gaps     = 1'b0;
		fill_ptr    = 0;
		cycle_count <= 0;
		arst_n      <= 1'b0;
		s_tvalid    <= 1'b0;
		s_tdata     <= '0;
		s_tuser     <= '0;
		m_tready    <= 1'b0;

		// key pool: VLAN extremes up front, then pairs that differ only in
		// VLAN or only in address so the two key halves are told apart
		for (int i = 0; i < PoolSize; i++) begin
			pool_vlan[i] = VlanW'($urandom_range(0, MaxVlanId));
			pool_ip[i]   = $urandom;
			if (i % 4 == 3) begin
				pool_vlan[i] = pool_vlan[i-1] ^ 12'h001;
				pool_ip[i]   = pool_ip[i-1];
			end else if (i % 7 == 6) begin
				pool_vlan[i] = pool_vlan[i-1];
				pool_ip[i]   = pool_ip[i-1] ^ 32'h1;
			end
		end
		pool_vlan[0] = '0;
		pool_vlan[1] = VlanW'(MaxVlanId);

		repeat (ResetCycles) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table first
		send_req(build_req(REQ_EXACT, 16'd0, 32'hFFFF_FFFF, '0, '0, '0));
		send_req(build_req(REQ_SUBNET, '0, '0, '0, '0, 32'h1234_5678));
		send_req(build_req(REQ_DELETE, 16'd0, 32'hFFFF_FFFF, '0, '0, '0));
		send_req(build_req(REQ_MODIFY, VlanInW'(MaxVlanId), 32'h0, 16'd7, '1, '0));
		// two entries at the field extremes: A exact /32, B matching anything
		send_req(build_req(REQ_ADD, 16'd0, 32'hFFFF_FFFF, VlanInW'(MaxVlanId), 32'hFFFF_FFFF,
			'0));
		send_req(build_req(REQ_ADD, VlanInW'(MaxVlanId), 32'h0, 16'd0, 32'h0, '0));
		// VLAN range rejects, key checked before value
		send_req(build_req(REQ_ADD, VlanInW'(MaxVlanId + 1), 32'hA5A5_A5A5, 16'd1, '1, '0));
		send_req(build_req(REQ_ADD, 16'hFFFF, 32'h5A5A_5A5A, 16'hFFFF, '1, '0));
		send_req(build_req(REQ_ADD, 16'd5, 32'h0A00_0001, VlanInW'(MaxVlanId + 1), '1, '0));
		send_req(build_req(REQ_MODIFY, 16'd0, 32'hFFFF_FFFF, 16'hFFFF, '0, '0));
		send_req(build_req(REQ_EXACT, 16'hFFFF, 32'hFFFF_FFFF, '0, '0, '0));
		send_req(build_req(REQ_DELETE, 16'h8000, 32'h0, '0, '0, '0));
		// hits, update in place by a repeated add, modify
		send_req(build_req(REQ_EXACT, 16'd0, 32'hFFFF_FFFF, '0, '0, '0));
		send_req(build_req(REQ_ADD, 16'd0, 32'hFFFF_FFFF, 16'h0ABC, 32'hFFFF_0000, '0));
		send_req(build_req(REQ_EXACT, 16'd0, 32'hFFFF_FFFF, '0, '0, '0));
		send_req(build_req(REQ_EXACT, VlanInW'(MaxVlanId), 32'hFFFF_FFFF, '0, '0, '0));
		send_req(build_req(REQ_MODIFY, VlanInW'(MaxVlanId), 32'h0, 16'h0555, 32'hFF00_0000,
			'0));
		// subnet: a hit on A, a hit on B, then a miss with the key fields ignored
		send_req(build_req(REQ_SUBNET, '0, '0, '0, '0, 32'hFFFF_1234));
		send_req(build_req(REQ_SUBNET, '0, '0, '0, '0, 32'h00AB_CDEF));
		send_req(build_req(REQ_SUBNET, 16'hFFFF, 32'hDEAD_BEEF, 16'hFFFF, '1, 32'h7F00_0001));
		// delete A, then a new key reuses the lowest free slot
		send_req(build_req(REQ_DELETE, 16'd0, 32'hFFFF_FFFF, '0, '0, '0));
		send_req(build_req(REQ_ADD, 16'd42, 32'hC0A8_0101, 16'd99, 32'hFFFF_FF00, '0));
		send_req(build_req(REQ_SUBNET, '0, '0, '0, '0, 32'hC0A8_01FE));
		// spare request codes
		for (int c = int'(REQ_SUBNET) + 1; c <= int'(ReqCodeTop); c++)
			send_req(build_req(ReqW'(c), 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, '1, '1));

		// random phases: fill to full, churn, drain; some with no idling
		for (int p = 0; p * PhaseItems < RandomItems; p++) begin
			case (p % 4)
				0:       mode = LOAD_FILL;
				2:       mode = LOAD_DRAIN;
				default: mode = LOAD_MIXED;
			endcase
			no_gaps = (p % 5 == 3);
			for (int n = 0; n < PhaseItems; n++)
				send_req(pick_request(mode));
		end
		no_gaps = 1'b0;
		s_tvalid <= 1'b0;

		while (shadow.due_results.size() != 0) @(posedge clk);
		repeat (TailCycles) @(posedge clk);

		$display("%0d results checked: %0d ok, %0d VLAN rejects, %0d misses, %0d table full",
			shadow.result_count, shadow.status_count[STAT_OK],
			shadow.status_count[STAT_BADVLAN], shadow.status_count[STAT_NOTFOUND],
			shadow.status_count[STAT_FULL]);
		$display("%0d lookup hits over fill, churn and drain phases; %0d bad beats",
			shadow.hit_count, shadow.mismatch_count);
		if (shadow.mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
